### design/dfq_pkg.sv
package dfq_pkg;

   // request operation codes
   typedef enum logic [1:0] {
      CMD_ENQ  = 2'd0,
      CMD_DEQ  = 2'd1,
      CMD_SHOW = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_DUP   = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_CMP,
      S_SHOW,
      S_RESP
   } state_type;

   // one result item handed from the sequencer to the output register
   typedef struct packed {
      status_type         status;
      logic signed [31:0] entry_value;
      logic [3:0]         position;
      logic               last;
   } rsp_type;

endpackage

### design/dfq_ram.sv
module dfq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port; read data holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### design/dfq_ctrl.sv
module dfq_ctrl #(
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_value,
   // output register handoff
   input  logic               out_free,
   output logic               push,
   output dfq_pkg::rsp_type   rsp_item,
   // entry memory
   output logic               ram_wr_en,
   output logic [AW-1:0]      ram_wr_addr,
   output logic [31:0]        ram_wr_data,
   output logic               ram_rd_en,
   output logic [AW-1:0]      ram_rd_addr,
   input  logic [31:0]        ram_rd_data
);

   import dfq_pkg::*;

   localparam int SW = AW + 1;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   status_type         status_ff, status_in;
   logic signed [31:0] value_ff, value_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      head_ff, head_in;

   logic          accept;
   logic          full;
   logic          empty;
   logic          match;
   logic          at_last;
   logic [CW-1:0] idx_nxt;

   // circular index: base plus offset, folded back below DEPTH
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = {1'b0, base} + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // shared compare unit and index arithmetic
   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign full        = (count_ff == CW'(DEPTH));
   assign empty       = (count_ff == '0);
   assign match       = (ram_rd_data == value_ff);
   assign idx_nxt     = idx_ff + CW'(1);
   assign at_last     = (idx_nxt == count_ff);
   assign ram_rd_addr = wrap_add(head_ff, idx_ff);
   assign ram_wr_addr = wrap_add(head_ff, count_ff);
   // append into an empty queue writes straight from the request
   assign ram_wr_data = (state_ff == S_IDLE) ? req_value : value_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (cmd_type'(req_cmd))
                  CMD_ENQ:  state_in = (full || empty) ? S_RESP : S_RD;
                  CMD_DEQ:  state_in = S_RESP;
                  CMD_SHOW: state_in = empty ? S_RESP : S_RD;
                  CMD_NONE: state_in = S_IDLE;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_RD:   state_in = (cmd_ff == CMD_ENQ) ? S_CMP : S_SHOW;
         S_CMP:  state_in = (match || at_last) ? S_RESP : S_RD;
         S_SHOW: begin
            if (out_free) begin
               state_in = at_last ? S_IDLE : S_RD;
            end
         end
         S_RESP: state_in = out_free ? S_IDLE : S_RESP;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      cmd_in    = cmd_ff;
      status_in = status_ff;
      value_in  = value_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      head_in   = head_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      push      = 1'b0;
      rsp_item  = '{status: ST_OK, entry_value: '0, position: '0, last: 1'b1};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = cmd_type'(req_cmd);
               value_in = req_value;
               idx_in   = '0;
               unique case (cmd_type'(req_cmd))
                  CMD_ENQ: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else if (empty) begin
                        // nothing to search: append at once
                        status_in = ST_OK;
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  CMD_DEQ: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        status_in = ST_OK;
                        head_in   = wrap_add(head_ff, CW'(1));
                        count_in  = count_ff - CW'(1);
                     end
                  end
                  CMD_SHOW: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end
                  end
                  CMD_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            ram_rd_en = 1'b1;
         end
         S_CMP: begin
            if (match) begin
               status_in = ST_DUP;
            end else if (at_last) begin
               // no entry matched: append at the tail
               status_in = ST_OK;
               ram_wr_en = 1'b1;
               count_in  = count_ff + CW'(1);
            end else begin
               idx_in = idx_nxt;
            end
         end
         S_SHOW: begin
            if (out_free) begin
               push     = 1'b1;
               rsp_item = '{status: ST_OK, entry_value: ram_rd_data,
                            position: 4'(idx_ff), last: at_last};
               idx_in   = idx_nxt;
            end
         end
         S_RESP: begin
            if (out_free) begin
               push     = 1'b1;
               rsp_item = '{status: status_ff, entry_value: '0, position: '0,
                            last: 1'b1};
            end
         end
         default: begin
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
      end
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      idx_ff    <= idx_in;
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("count exceeds depth");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result pushed into a busy output register");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !full)
      else $error("append while queue is full");

   a_full_refuse: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_ENQ && full) |=>
         (state_ff == S_RESP && status_ff == ST_FULL && full))
      else $error("enqueue on full queue not refused");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_CMP || state_ff == S_SHOW) |->
         (idx_ff < count_ff))
      else $error("scan index past valid entries");
`endif

endmodule

### design/dedup_fifo_queue.sv
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | req_cmd, req_value
// rsp     | out       | rsp_valid / rsp_ready  | rsp_status, rsp_entry_value,
//         |           |                        | rsp_position, rsp_last
//
// Entries sit in a circular buffer in one RAM; one compare unit walks them.
// Enqueue: straight to S_RESP with an empty or full queue, else S_RD and S_CMP
// per entry compared, then S_RESP. Dequeue: straight to S_RESP. Display: S_RESP
// if empty, else S_RD and S_SHOW per entry; S_RD does the registered RAM read.
// Reset empties the queue at once; entry contents are left as they are.
// A stalled rsp channel holds the sequencer; req_ready is low until done.
module dedup_fifo_queue #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_entry_value,
   output logic [3:0]         rsp_position,
   output logic               rsp_last
);

   import dfq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic          out_free;
   logic          push;
   rsp_type       rsp_item;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [31:0]   ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [31:0]   ram_rd_data;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   dfq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_value   (req_value),
      .out_free    (out_free),
      .push        (push),
      .rsp_item    (rsp_item),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   dfq_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (push) begin
         rsp_data_ff <= rsp_item;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_entry_value = rsp_data_ff.entry_value;
   assign rsp_position    = rsp_data_ff.position;
   assign rsp_last        = rsp_data_ff.last;

endmodule
